// File: rtl/shuffled_index_draw_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SHUFFLED_INDEX_DRAW_UNIT_ASSERT_SVH
`define SHUFFLED_INDEX_DRAW_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIDU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sidu assertion failed");

// Next-cycle implication, disabled during reset.
`define SIDU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sidu assertion failed");

`endif

// File: rtl/sidu_pkg.sv
`default_nettype none

package sidu_pkg;

  localparam int unsigned CNT_W  = 9;
  localparam int unsigned RW_W   = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned PROD_W = RW_W + CNT_W;

  typedef struct packed {
    logic latch_rw;
    logic rd_en;
    logic use_rw_q;
    logic fill_start;
    logic fill_we;
    logic fill_end;
    logic commit;
    logic empty_out;
  } cmd_t;

  typedef struct packed {
    logic remain_zero;
    logic eff_zero;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/sidu_ctrl.sv
`default_nettype none

module sidu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire sidu_pkg::sts_t sts_i,
  output sidu_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFill  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StEmpty = 3'd4;

  logic [2:0] state_q, state_d;
  logic       in_acc;

  assign in_acc = in_valid_i && !cfg_valid_i && (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        cfg_ready_o = 1'b1;
        in_stall_o  = cfg_valid_i;
        if (in_acc) begin
          cmd_o.latch_rw = 1'b1;
          if (!sts_i.remain_zero) begin
            cmd_o.rd_en = 1'b1;
            state_d     = StWrite;
          end else if (sts_i.eff_zero) begin
            state_d = StEmpty;
          end else begin
            cmd_o.fill_start = 1'b1;
            state_d          = StFill;
          end
        end
      end
      StFill: begin
        cmd_o.fill_we = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.fill_end = 1'b1;
          state_d        = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.use_rw_q = 1'b1;
        state_d        = StWrite;
      end
      StWrite: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      StEmpty: begin
        if (sts_i.out_free) begin
          cmd_o.empty_out = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sidu_datapath.sv
`default_nettype none

module sidu_datapath #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sidu_pkg::cmd_t               cmd_i,
  output sidu_pkg::sts_t                    sts_o,
  input  wire logic [sidu_pkg::RW_W-1:0]    random_word_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [sidu_pkg::CNT_W-1:0]   entry_count_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic [sidu_pkg::IDX_W-1:0]        drawn_index_o,
  output logic                              pass_done_o,
  output logic                              empty_flag_o
);

  localparam int unsigned AddrW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntMax = (1 << sidu_pkg::CNT_W) - 1;
  localparam int unsigned CapLim = (MAX_ENTRIES > CntMax) ? CntMax : MAX_ENTRIES;

  logic [sidu_pkg::IDX_W-1:0]  pool_mem [MAX_ENTRIES];

  logic [sidu_pkg::CNT_W-1:0]  entry_count_q;
  logic [sidu_pkg::CNT_W-1:0]  remaining_q;
  logic [sidu_pkg::CNT_W-1:0]  fill_cnt_q;
  logic [sidu_pkg::RW_W-1:0]   rw_q;
  logic [AddrW-1:0]            slot_q;
  logic [sidu_pkg::IDX_W-1:0]  rd_slot_q;
  logic [sidu_pkg::IDX_W-1:0]  rd_last_q;
  logic                        out_valid_q;
  logic [sidu_pkg::IDX_W-1:0]  out_index_q;
  logic                        out_pass_q;
  logic                        out_empty_q;

  logic [sidu_pkg::CNT_W-1:0]  eff_cnt;
  logic [sidu_pkg::RW_W-1:0]   rw_sel;
  logic [sidu_pkg::PROD_W-1:0] product;
  logic [sidu_pkg::CNT_W-1:0]  slot;
  logic [sidu_pkg::CNT_W-1:0]  last;
  logic                        out_free;

  assign eff_cnt = (entry_count_q > sidu_pkg::CNT_W'(CapLim))
                 ? sidu_pkg::CNT_W'(CapLim) : entry_count_q;
  assign rw_sel  = cmd_i.use_rw_q ? rw_q : random_word_i;
  assign product = sidu_pkg::PROD_W'(rw_sel) * sidu_pkg::PROD_W'(remaining_q);
  assign slot    = product[sidu_pkg::PROD_W-1:sidu_pkg::RW_W];
  assign last    = remaining_q - sidu_pkg::CNT_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.remain_zero = (remaining_q == '0);
  assign sts_o.eff_zero    = (eff_cnt == '0);
  assign sts_o.fill_last   = (fill_cnt_q == eff_cnt - sidu_pkg::CNT_W'(1));
  assign sts_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      remaining_q   <= '0;
      fill_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= entry_count_i;
        remaining_q   <= '0;
      end else if (cmd_i.fill_end) begin
        remaining_q <= eff_cnt;
      end else if (cmd_i.commit) begin
        remaining_q <= last;
      end
      if (cmd_i.fill_start) begin
        fill_cnt_q <= '0;
      end else if (cmd_i.fill_we) begin
        fill_cnt_q <= fill_cnt_q + sidu_pkg::CNT_W'(1);
      end
      if (cmd_i.commit || cmd_i.empty_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_rw) begin
      rw_q <= random_word_i;
    end
    if (cmd_i.commit) begin
      out_index_q <= rd_slot_q;
      out_pass_q  <= (last == '0);
      out_empty_q <= 1'b0;
    end else if (cmd_i.empty_out) begin
      out_index_q <= '0;
      out_pass_q  <= 1'b0;
      out_empty_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_we) begin
      pool_mem[AddrW'(fill_cnt_q)] <= sidu_pkg::IDX_W'(fill_cnt_q);
    end else if (cmd_i.commit) begin
      pool_mem[slot_q] <= rd_last_q;
    end
    if (cmd_i.rd_en) begin
      rd_slot_q <= pool_mem[AddrW'(slot)];
      rd_last_q <= pool_mem[AddrW'(last)];
      slot_q    <= AddrW'(slot);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drawn_index_o = out_index_q;
  assign pass_done_o   = out_pass_q;
  assign empty_flag_o  = out_empty_q;

endmodule

`default_nettype wire

// File: rtl/shuffled_index_draw_unit.sv
// Shuffled index draw unit: hands out 0..N-1 in random order, each once per pass.
// Input channel: in_valid_i / in_stall_o carry one 16-bit random_word_i per
// transaction; every accepted transaction yields exactly one result.
// Output channel: out_valid_o / out_stall_i carry drawn_index_o, pass_done_o
// (last index of the pass) and empty_flag_o (N is zero, index reads 0).
// Config channel: cfg_valid_i / cfg_ready_o write entry_count_i (N); ready only
// while the controller is idle, and a write restarts the pass.
// Flow: a draw reads the slot and the last live entry over two memory read
// ports (on acceptance, or in StRead after a refill), then writes back in
// StWrite, which also loads the output register; the write-back waits while
// the output is stalled, and no new transaction is taken until it is done.
// The first draw of a pass first refills the pool one entry per cycle, with N
// saturated to MAX_ENTRIES (at most 511), and then reads in StRead.
// Reset clears N, the remaining count and the output valid; pool contents stay
// unknown until a refill writes them.
// A stalled result stays in the output register; the next transaction is still
// accepted and worked on, and its write-back waits until the register frees.
`default_nettype none

module shuffled_index_draw_unit #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [sidu_pkg::RW_W-1:0]  random_word_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [sidu_pkg::CNT_W-1:0] entry_count_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [sidu_pkg::IDX_W-1:0]      drawn_index_o,
  output logic                            pass_done_o,
  output logic                            empty_flag_o
);

  sidu_pkg::cmd_t cmd;
  sidu_pkg::sts_t sts;

  sidu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sidu_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .random_word_i (random_word_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .entry_count_i (entry_count_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .drawn_index_o (drawn_index_o),
    .pass_done_o   (pass_done_o),
    .empty_flag_o  (empty_flag_o)
  );

endmodule

`default_nettype wire

// File: rtl/sidu_checker.sv
`default_nettype none

`include "shuffled_index_draw_unit_assert.svh"

module sidu_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [sidu_pkg::IDX_W-1:0] drawn_index_o,
  input wire logic                       pass_done_o,
  input wire logic                       empty_flag_o
);

  `SIDU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(drawn_index_o))
  `SIDU_ASSERT_IMP(a_empty_zero, out_valid_o && empty_flag_o, drawn_index_o == '0 && !pass_done_o)
  `SIDU_ASSERT_NXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o && !cfg_ready_o)
  `SIDU_ASSERT_IMP(a_cfg_excl, cfg_valid_i && cfg_ready_o, in_stall_o)

endmodule

bind shuffled_index_draw_unit sidu_checker u_sidu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drawn_index_o (drawn_index_o),
  .pass_done_o   (pass_done_o),
  .empty_flag_o  (empty_flag_o)
);

`default_nettype wire
